>>> hw/rtl/tdrs_pkg.sv
// Package for the 2D range-sum tree: field widths and shared types.
// No dependencies.
package tdrs_pkg;
  localparam int unsigned CoordW = 6;
  localparam int unsigned AmtW   = 32;
  localparam int unsigned SumW   = 64;

  typedef enum logic {ActAdd = 1'b0, ActQuery = 1'b1} action_e;
  typedef enum logic {StatOk = 1'b0, StatRange = 1'b1} status_e;

  typedef struct packed {
    logic               action;
    logic [CoordW-1:0]  row_first;
    logic [CoordW-1:0]  col_first;
    logic [CoordW-1:0]  row_last;
    logic [CoordW-1:0]  col_last;
    logic signed [AmtW-1:0] amount;
  } req_t;

  typedef struct packed {
    logic signed [SumW-1:0] range_sum;
    logic                   status;
  } rsp_t;
endpackage

>>> hw/rtl/tdrs_if.sv
// Valid/ready channel interface carrying a typed payload.
// Depends on tdrs_pkg.
interface tdrs_req_if import tdrs_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tdrs_rsp_if import tdrs_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/two_d_range_sum_tree_core.sv
// Top level of the 2D range-sum segment tree: sequencer, tree memory, adder.
// Depends on tdrs_pkg and tdrs_if.
//
// Keeps a two-level segment tree of 64-bit sums (2*ROWS x 2*COLS words) in
// one single-port memory. One beat in gives one beat out. After reset a
// clearing pass writes every word to zero, during which no beat is taken.
// Each node visit is a read, then for an add a write back through the
// shared 64-bit adder; the memory port sets the pace. An add visits every
// node on the leaf-to-root path of both levels. A query walks the outer
// levels and, for each outer node that it takes, runs a setup step, then
// walks the inner levels, reading and accumulating each inner node that it
// takes. Coordinates outside the grid and empty ranges go straight to the
// response. The result sits in an output register, so the next beat is
// taken while the sink stalls; the core only waits at the end of that next
// beat if the old result is still unread.
module two_d_range_sum_tree_core import tdrs_pkg::*; #(
  parameter int unsigned ROWS = 64,
  parameter int unsigned COLS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tdrs_req_if.sink   req_i,
  tdrs_rsp_if.source rsp_o
);
  localparam int unsigned RB = $clog2(ROWS) + 1;  // outer index bits
  localparam int unsigned CB = $clog2(COLS) + 1;  // inner index bits
  localparam int unsigned AW = RB + CB;

  typedef enum logic [3:0] {
    SClear, SIdle, SAddRd, SAddWr, SQRow, SQColInit, SQCol, SQAcc, SResp
  } state_e;

  state_e        state_q;
  logic [AW-1:0] clr_q;
  logic [RB-1:0] ri_q;               // add row index
  logic [RB:0]   rl_q, rr_q;         // query row l,r (r may reach 2*ROWS)
  logic [CB-1:0] cj_q;               // add col index
  logic [CB:0]   cl_q, cr_q;         // query col l,r
  logic [RB-1:0] cur_row_q;
  logic [CB-1:0] c0_q;
  logic [CB:0]   c1_q;
  logic          rtail_q;            // row l side pending (0) or r side (1)
  logic [SumW-1:0] amt_q, acc_q;
  logic          stat_q;
  logic          rsp_valid_q;
  rsp_t          rsp_q;

  logic [RB:0]   rr_dec;
  logic [CB:0]   cr_dec;
  logic [CB-1:0] col_sel;
  assign rr_dec  = rr_q - (RB+1)'(1);
  assign cr_dec  = cr_q - (CB+1)'(1);
  assign col_sel = cl_q[0] ? cl_q[CB-1:0] : cr_dec[CB-1:0];

  // memory
  logic [SumW-1:0] mem [2**AW];
  logic            we;
  logic [AW-1:0]   addr;
  logic [SumW-1:0] wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[addr] <= wdata;
    rdata_q <= mem[addr];
  end

  // shared adder
  logic [SumW-1:0] add_a, sum;
  assign sum = add_a + rdata_q;

  always_comb begin
    we = 1'b0; addr = {ri_q, cj_q}; wdata = sum; add_a = amt_q;
    case (state_q)
      SClear: begin we = 1'b1; addr = clr_q; wdata = '0; end
      SAddRd: addr = {ri_q, cj_q};
      SAddWr: begin we = 1'b1; addr = {ri_q, cj_q}; end
      SQCol:  addr = {cur_row_q, col_sel};
      SQAcc:  add_a = acc_q;
      default: ;
    endcase
  end

  logic in_add_bad, in_q_bad;
  assign in_add_bad = (32'(req_i.data.row_first) >= ROWS) ||
                      (32'(req_i.data.col_first) >= COLS);
  assign in_q_bad = in_add_bad ||
                    (32'(req_i.data.row_last) >= ROWS) ||
                    (32'(req_i.data.col_last) >= COLS);

  assign req_i.ready  = (state_q == SIdle);
  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.data   = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear; clr_q <= '0; rsp_valid_q <= 1'b0;
      ri_q <= '0; cj_q <= '0; rl_q <= '0; rr_q <= '0; cl_q <= '0; cr_q <= '0;
      cur_row_q <= '0; c0_q <= '0; c1_q <= '0; rtail_q <= 1'b0;
      amt_q <= '0; acc_q <= '0; stat_q <= StatOk; rsp_q <= '0;
    end else begin
      case (state_q)
        SClear: begin
          clr_q <= clr_q + AW'(1);
          if (&clr_q) state_q <= SIdle;
        end
        SIdle: if (req_i.valid) begin
          amt_q <= {{(SumW-AmtW){req_i.data.amount[AmtW-1]}}, req_i.data.amount};
          acc_q <= '0;
          ri_q  <= RB'(req_i.data.row_first) + RB'(ROWS);
          cj_q  <= CB'(req_i.data.col_first) + CB'(COLS);
          c0_q  <= CB'(req_i.data.col_first) + CB'(COLS);
          c1_q  <= (CB+1)'(req_i.data.col_last) + (CB+1)'(COLS) + (CB+1)'(1);
          rl_q  <= (RB+1)'(req_i.data.row_first) + (RB+1)'(ROWS);
          rr_q  <= (RB+1)'(req_i.data.row_last) + (RB+1)'(ROWS) + (RB+1)'(1);
          rtail_q <= 1'b0;
          if (req_i.data.action == ActAdd) begin
            stat_q <= in_add_bad ? StatRange : StatOk;
            state_q <= in_add_bad ? SResp : SAddRd;
          end else begin
            stat_q <= in_q_bad ? StatRange : StatOk;
            if (in_q_bad || req_i.data.row_first > req_i.data.row_last ||
                req_i.data.col_first > req_i.data.col_last) state_q <= SResp;
            else state_q <= SQRow;
          end
        end
        SAddRd: state_q <= SAddWr;
        SAddWr: begin
          if (cj_q == CB'(1)) begin
            cj_q <= c0_q;
            ri_q <= ri_q >> 1;
            state_q <= (ri_q == RB'(1)) ? SResp : SAddRd;
          end else begin
            cj_q <= cj_q >> 1;
            state_q <= SAddRd;
          end
        end
        // outer walk: pick next row node, or climb
        SQRow: begin
          if (rl_q >= rr_q) begin
            state_q <= SResp;
          end else if (!rtail_q && rl_q[0]) begin
            cur_row_q <= rl_q[RB-1:0]; rl_q <= rl_q + (RB+1)'(1);
            rtail_q <= 1'b1; state_q <= SQColInit;
          end else if (rr_q[0]) begin
            cur_row_q <= rr_dec[RB-1:0];
            rtail_q <= 1'b0;
            rl_q <= rl_q >> 1; rr_q <= rr_dec >> 1;
            state_q <= SQColInit;
          end else begin
            rtail_q <= 1'b0;
            rl_q <= rl_q >> 1; rr_q <= rr_q >> 1;
          end
        end
        SQColInit: begin cl_q <= {1'b0, c0_q}; cr_q <= c1_q; state_q <= SQCol; end
        SQCol: begin
          if (cl_q >= cr_q) state_q <= SQRow;
          else if (cl_q[0]) begin
            cl_q <= cl_q + (CB+1)'(1); state_q <= SQAcc;
          end else if (cr_q[0]) begin
            cr_q <= cr_dec; state_q <= SQAcc;
          end else begin
            cl_q <= cl_q >> 1; cr_q <= cr_q >> 1;
          end
        end
        SQAcc: begin acc_q <= sum; state_q <= SQCol; end
        SResp: if (!rsp_valid_q) begin
          rsp_q.range_sum <= acc_q;
          rsp_q.status <= stat_q;
          rsp_valid_q <= 1'b1; state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
      if (rsp_valid_q && rsp_o.ready) rsp_valid_q <= 1'b0;
    end
  end
endmodule

>>> tb/sv/two_d_range_sum_tree_core_tb.sv
// Testbench for two_d_range_sum_tree_core: random add/query beats checked
// against a flat-grid sum predictor. Depends on tdrs_pkg, tdrs_if and the core.
module two_d_range_sum_tree_core_tb;
  import tdrs_pkg::*;

  localparam int unsigned Rows = 64;
  localparam int unsigned Cols = 64;
  localparam int unsigned NumRandom = 1800;
  // Clearing pass plus ~2000 beats at worst-case pace and long stalls.
  localparam longint CycleLimit = 64'd4000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tdrs_req_if req_bus ();
  tdrs_rsp_if rsp_bus ();

  two_d_range_sum_tree_core #(.ROWS(Rows), .COLS(Cols)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus.sink),
    .rsp_o  (rsp_bus.source)
  );

  // Predictor state: plain cell values; sums taken by brute force.
  logic [SumW-1:0] cell_val [Rows][Cols];
  req_t pending_beats [$];
  rsp_t expected_sums [$];
  int   fail_count = 0;
  longint cycle_count = 0;
  bit   stim_done = 1'b0;
  bit   hold_for_drain = 1'b0;
  int   send_gap = 0;
  int   stall_gap = 0;

  function automatic rsp_t predict_beat(req_t b);
    rsp_t r;
    logic [SumW-1:0] acc;
    r.range_sum = '0;
    r.status = StatOk;
    if (b.action == ActAdd) begin
      if (b.row_first >= Rows || b.col_first >= Cols) r.status = StatRange;
      else cell_val[b.row_first][b.col_first] += {{(SumW-AmtW){b.amount[AmtW-1]}}, b.amount};
    end else begin
      if (b.row_first >= Rows || b.row_last >= Rows ||
          b.col_first >= Cols || b.col_last >= Cols) begin
        r.status = StatRange;
      end else begin
        acc = '0;
        for (int i = b.row_first; i <= b.row_last; i++)
          for (int j = b.col_first; j <= b.col_last; j++) acc += cell_val[i][j];
        r.range_sum = acc;
      end
    end
    return r;
  endfunction

  function automatic int rand_gap();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(200, 20);
  endfunction

  task automatic report_mismatch(string what, rsp_t got, rsp_t want);
    $display("mismatch %s: got sum=%0h st=%0b want sum=%0h st=%0b",
             what, got.range_sum, got.status, want.range_sum, want.status);
    fail_count++;
  endtask

  function automatic req_t make_beat(logic act, int r0, int c0, int r1, int c1, int amt);
    req_t b;
    b.action = act;
    b.row_first = r0[CoordW-1:0];
    b.col_first = c0[CoordW-1:0];
    b.row_last = r1[CoordW-1:0];
    b.col_last = c1[CoordW-1:0];
    b.amount = amt;
    return b;
  endfunction

  function automatic req_t rand_beat();
    req_t b;
    int p;
    b = req_t'(($bits(req_t))'({$urandom, $urandom}));
    p = $urandom_range(99);
    // Mostly narrow rectangles keep the predictor quick; the rest take random bounds.
    if (b.action == ActQuery && p < 70) begin
      b.row_last = b.row_first + CoordW'($urandom_range(7));
      b.col_last = b.col_first + CoordW'($urandom_range(7));
    end
    if (p >= 90) b.amount = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    return b;
  endfunction

  initial begin
    for (int i = 0; i < Rows; i++)
      for (int j = 0; j < Cols; j++) cell_val[i][j] = '0;
    // Directed: corners, extremes, empty ranges, full grid, wrap.
    pending_beats.push_back(make_beat(ActQuery, 0, 0, 63, 63, 0));
    pending_beats.push_back(make_beat(ActAdd, 0, 0, 0, 0, 32'h7fffffff));
    pending_beats.push_back(make_beat(ActAdd, 63, 63, 63, 63, 32'h80000000));
    pending_beats.push_back(make_beat(ActAdd, 0, 63, 17, 42, -5));
    pending_beats.push_back(make_beat(ActAdd, 63, 0, 0, 0, 123456));
    pending_beats.push_back(make_beat(ActQuery, 0, 0, 63, 63, 0));
    pending_beats.push_back(make_beat(ActQuery, 0, 0, 0, 0, -1));
    pending_beats.push_back(make_beat(ActQuery, 63, 63, 63, 63, 0));
    pending_beats.push_back(make_beat(ActQuery, 5, 0, 4, 63, 0));
    pending_beats.push_back(make_beat(ActQuery, 0, 9, 63, 8, 0));
    pending_beats.push_back(make_beat(ActQuery, 63, 63, 0, 0, 0));
    pending_beats.push_back(make_beat(ActQuery, 0, 0, 63, 0, 0));
    pending_beats.push_back(make_beat(ActQuery, 0, 0, 0, 63, 0));
    for (int k = 0; k < 4; k++)
      pending_beats.push_back(make_beat(ActAdd, 7, 7, 0, 0, 32'h80000000));
    pending_beats.push_back(make_beat(ActQuery, 0, 0, 63, 63, 0));
    pending_beats.push_back(make_beat(ActQuery, 7, 7, 7, 7, 0));
    while (pending_beats.size() != 0 || req_bus.valid) @(posedge clk_i);
    hold_for_drain = 1'b1;
    while (expected_sums.size() != 0) @(posedge clk_i);
    hold_for_drain = 1'b0;
    for (int k = 0; k < NumRandom; k++) pending_beats.push_back(rand_beat());
    while (pending_beats.size() != 0 || req_bus.valid) @(posedge clk_i);
    stim_done = 1'b1;
  end

  // Driver: one beat at a time with random gaps; holds valid until accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
      req_bus.data <= '0;
      send_gap <= 0;
    end else if (req_bus.valid && !req_bus.ready) begin
      // hold
    end else begin
      if (req_bus.valid) expected_sums.push_back(predict_beat(req_bus.data));
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req_bus.valid <= 1'b0;
      end else if (pending_beats.size() != 0 && !hold_for_drain) begin
        req_bus.valid <= 1'b1;
        req_bus.data <= pending_beats.pop_front();
        send_gap <= rand_gap();
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Monitor: random stalls on ready, compares each result with the oldest.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
      stall_gap <= 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_sums.size() == 0) begin
          report_mismatch("unexpected", rsp_bus.data, '0);
        end else begin
          rsp_t want;
          want = expected_sums.pop_front();
          if (rsp_bus.data.range_sum !== want.range_sum)
            report_mismatch("range_sum", rsp_bus.data, want);
          if (rsp_bus.data.status !== want.status)
            report_mismatch("status", rsp_bus.data, want);
        end
      end
      if (stall_gap > 0) begin
        stall_gap <= stall_gap - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
        stall_gap <= ($urandom_range(3) == 0) ? rand_gap() : 0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done);
    while (expected_sums.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
